@@ src/bal_pkg.sv @@
package bal_pkg;

   // list geometry
   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = 8;
   localparam int POS_W    = 8;
   localparam int KEY_W    = 32;
   localparam int HDL_W    = 32;
   localparam int CMD_W    = 3;
   localparam int ST_W     = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [ST_W-1:0] ST_NOKEY  = 2'd3;

   // one stored entry
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [HDL_W-1:0]        handle;
   } entry_type;

   // input item
   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [KEY_W-1:0] entry_key;
      logic [HDL_W-1:0]        entry_handle;
      logic [POS_W-1:0]        position;
   } req_type;

   // result item
   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [KEY_W-1:0] found_key;
      logic [HDL_W-1:0]        found_handle;
      logic [CNT_W-1:0]        entry_count;
      logic                    is_empty;
      logic                    is_full;
   } rsp_type;

endpackage

@@ src/bal_store.sv @@
module bal_store
   import bal_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // single read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_array_list_engine.sv @@
// Bounded ordered list of up to 128 (key, handle) entries held in one single-port-read,
// single-port-write memory, walked one entry per cycle by a small sequencer. One command
// is taken at a time and req_stall stays high until its result is formed. Append and
// remove at the last position finish in the start step, read passes through the scan step
// and insert at the end through the place step, each ahead of the done step; find,
// delete-by-key, insert and remove walk the entries they touch at one memory read per cycle.
// A stalled result holds the block in its last step until it leaves. Bad positions and
// a full list are reported in status and leave the list as it was; found_key and
// found_handle are zero except on a successful find or read.
module bounded_array_list_engine
   import bal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_SCAN  = 6'b000100,
      S_SHIFT = 6'b001000,
      S_PLACE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ST_W-1:0]  status_ff, status_in;
   entry_type        found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [CNT_W-1:0] wr_ptr;
   entry_type        wr_data;
   logic             rd_en;
   logic [CNT_W-1:0] rd_ptr;
   entry_type        rd_data;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic [CNT_W-1:0] pos_c;
   logic [CNT_W-1:0] pos_m1;
   logic             is_full;
   logic             is_empty;
   logic             bad_at;
   logic             bad_ins;
   logic             key_hit;
   logic             scan_last;
   logic [CNT_W-1:0] kept;
   logic             rsp_free;

   bal_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // position and fill checks
   assign pos_x     = CMP_W'(cmd_ff.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign pos_c     = CNT_W'(cmd_ff.position);
   assign pos_m1    = pos_c - CNT_W'(1);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign bad_at    = (pos_x == '0) || (pos_x > cnt_x);
   assign bad_ins   = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));

   // shared compare on the entry coming out of the memory
   assign key_hit   = (rd_data.key == cmd_ff.entry_key);
   assign scan_last = ((rd_ptr_ff + CNT_W'(1)) == count_ff);
   assign kept      = wr_ptr_ff + CNT_W'(!key_hit);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_ptr       = wr_ptr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_ptr       = rd_ptr_ff;

      // result leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               state_in = S_START;
            end
         end

         S_START: begin
            status_in = ST_OK;
            found_in  = '0;
            state_in  = S_DONE;
            case (cmd_ff.command)
               CMD_APPEND: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     wr_ptr         = count_ff;
                     wr_data.key    = cmd_ff.entry_key;
                     wr_data.handle = cmd_ff.entry_handle;
                     count_in       = count_ff + CNT_W'(1);
                  end
               end
               CMD_DELETE, CMD_FIND: begin
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
                  if (is_empty) begin
                     status_in = ST_NOKEY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_ptr   = '0;
                     state_in = S_SCAN;
                  end
               end
               CMD_INSERT: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else if (bad_ins) begin
                     status_in = ST_BADPOS;
                  end else if (pos_x == cnt_x + CMP_W'(1)) begin
                     state_in = S_PLACE;
                  end else begin
                     wr_ptr_in = count_ff;
                     rd_en     = 1'b1;
                     rd_ptr    = count_ff - CNT_W'(1);
                     state_in  = S_SHIFT;
                  end
               end
               CMD_REMOVE: begin
                  if (bad_at) begin
                     status_in = ST_BADPOS;
                  end else if (pos_c == count_ff) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     wr_ptr_in = pos_m1;
                     rd_en     = 1'b1;
                     rd_ptr    = pos_c;
                     state_in  = S_SHIFT;
                  end
               end
               CMD_READ: begin
                  if (bad_at) begin
                     status_in = ST_BADPOS;
                  end else begin
                     rd_en    = 1'b1;
                     rd_ptr   = pos_m1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end

         // one stored entry per cycle through the compare
         S_SCAN: begin
            case (cmd_ff.command)
               CMD_FIND: begin
                  if (key_hit) begin
                     found_in = rd_data;
                     state_in = S_DONE;
                  end else if (scan_last) begin
                     status_in = ST_NOKEY;
                     state_in  = S_DONE;
                  end else begin
                     rd_ptr_in = rd_ptr_ff + CNT_W'(1);
                     rd_en     = 1'b1;
                     rd_ptr    = rd_ptr_ff + CNT_W'(1);
                  end
               end
               CMD_DELETE: begin
                  // compact survivors toward the front
                  wr_en     = !key_hit;
                  wr_ptr    = wr_ptr_ff;
                  wr_ptr_in = kept;
                  if (scan_last) begin
                     count_in  = kept;
                     status_in = (kept == count_ff) ? ST_NOKEY : ST_OK;
                     state_in  = S_DONE;
                  end else begin
                     rd_ptr_in = rd_ptr_ff + CNT_W'(1);
                     rd_en     = 1'b1;
                     rd_ptr    = rd_ptr_ff + CNT_W'(1);
                  end
               end
               default: begin
                  // read at position
                  found_in = rd_data;
                  state_in = S_DONE;
               end
            endcase
         end

         // move one entry per cycle
         S_SHIFT: begin
            wr_en  = 1'b1;
            wr_ptr = wr_ptr_ff;
            if (cmd_ff.command == CMD_INSERT) begin
               if (wr_ptr_ff == pos_c) begin
                  state_in = S_PLACE;
               end else begin
                  wr_ptr_in = wr_ptr_ff - CNT_W'(1);
                  rd_en     = 1'b1;
                  rd_ptr    = wr_ptr_ff - CNT_W'(2);
               end
            end else begin
               if ((wr_ptr_ff + CNT_W'(2)) == count_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  wr_ptr_in = wr_ptr_ff + CNT_W'(1);
                  rd_en     = 1'b1;
                  rd_ptr    = wr_ptr_ff + CNT_W'(2);
               end
            end
         end

         // new entry into the opened slot
         S_PLACE: begin
            wr_en          = 1'b1;
            wr_ptr         = pos_m1;
            wr_data.key    = cmd_ff.entry_key;
            wr_data.handle = cmd_ff.entry_handle;
            count_in       = count_ff + CNT_W'(1);
            state_in       = S_DONE;
         end

         // hand the item to the output register
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.found_key    = found_ff.key;
               rsp_data_in.found_handle = found_ff.handle;
               rsp_data_in.entry_count  = count_ff;
               rsp_data_in.is_empty     = is_empty;
               rsp_data_in.is_full      = is_full;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
